@@ hdl/udp_demux_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// UDP port demultiplexer package
// Shared sizes, operation codes, status codes and sequencer states for the
// destination port demultiplexer.
// ---------------------------------------------------------------------------
package udp_demux_pkg;

	// Number of port bindings held in the table.
	localparam int TABLE_ENTRIES = 8;
	// Width of an index into the table.
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// Bytes in a UDP header.
	localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

	// Item operations.
	typedef enum logic {
		OP_REGISTER = 1'b0,
		OP_DISPATCH = 1'b1
	} op_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_BOUND     = 3'd0,
		ST_FULL      = 3'd1,
		ST_DELIVERED = 3'd2,
		ST_SHORT     = 3'd3,
		ST_BADLEN    = 3'd4,
		ST_NOHANDLER = 3'd5
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_SCAN,
		SQ_DONE
	} seq_state_t;

endpackage : udp_demux_pkg
`default_nettype wire

@@ hdl/udp_demux_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// UDP port demultiplexer channels
// Request channel (binding or received header) and result channel, each with
// a valid/ready handshake; a beat moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface udp_demux_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] port;
	logic [7:0]  handler_id;
	logic [31:0] source_address;
	logic [15:0] header_source_port;
	logic [15:0] header_length;
	logic [15:0] frame_length;

	modport source (
		output valid, operation, port, handler_id, source_address,
		       header_source_port, header_length, frame_length,
		input  ready
	);
	modport sink (
		input  valid, operation, port, handler_id, source_address,
		       header_source_port, header_length, frame_length,
		output ready
	);
endinterface : udp_demux_req_if

interface udp_demux_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  target_handler;
	logic [31:0] sender_address;
	logic [15:0] sender_port;
	logic [15:0] payload_length;

	modport source (
		output valid, status, target_handler, sender_address, sender_port,
		       payload_length,
		input  ready
	);
	modport sink (
		input  valid, status, target_handler, sender_address, sender_port,
		       payload_length,
		output ready
	);
endinterface : udp_demux_res_if
`default_nettype wire

@@ hdl/udp_port_demultiplexer_core.sv @@
`default_nettype none
// A binding or dispatch beat is accepted, then scans 1 to 8 table entries in turn
// (one entry per cycle through a single port comparator), then the result is offered.
// Dropped dispatch beats (short frame, bad length) skip the scan: result offered next cycle.
// The core takes one item at a time; a new request is accepted only once the result is taken.
// Reset: arst_n clears the sequencer and all used marks, so the table starts empty.
// ---------------------------------------------------------------------------
// UDP destination port demultiplexer core
// Keeps a table of port bindings, binds handlers to ports and routes received
// datagram headers to the handler bound to their destination port.
// ---------------------------------------------------------------------------
module udp_port_demultiplexer_core
	import udp_demux_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	udp_demux_req_if.sink    request,
	udp_demux_res_if.source  result
);

	// Binding table: used marks reset, port and handler only matter when used.
	logic [TABLE_ENTRIES-1:0] bind_used_q;
	logic [15:0]              bind_port_q    [TABLE_ENTRIES];
	logic [7:0]               bind_handler_q [TABLE_ENTRIES];

	// Captured item.
	op_t         item_op_q;
	logic [15:0] item_port_q;
	logic [7:0]  item_handler_q;
	logic [31:0] item_saddr_q;
	logic [15:0] item_sport_q;
	logic [15:0] item_plen_q;

	// Sequencer and scan bookkeeping.
	seq_state_t       state_q, state_next;
	logic [IDX_W-1:0] scan_idx_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	// Result registers.
	status_t    res_status_q;
	logic [7:0] res_handler_q;

	// Decode signals.
	logic       req_accept;
	logic       req_short;
	logic       req_badlen;
	logic       scan_active;
	logic       scan_port_eq;
	logic       scan_hit;
	logic       scan_free;
	logic       scan_last;
	logic       res_delivered;
	logic [15:0] req_min_len;

	// Input checks made at acceptance.
	assign req_accept  = request.valid && request.ready;
	assign req_short   = request.frame_length < UDP_HDR_BYTES;
	assign req_badlen  = request.header_length < UDP_HDR_BYTES;
	assign req_min_len = (request.header_length < request.frame_length) ?
	                     request.header_length : request.frame_length;

	// Shared comparator on the entry under the scan index.
	assign scan_port_eq = bind_port_q[scan_idx_q] == item_port_q;
	assign scan_hit     = bind_used_q[scan_idx_q] && scan_port_eq &&
	                      ((item_op_q == OP_REGISTER) || (bind_handler_q[scan_idx_q] != 8'd0));
	assign scan_free    = !bind_used_q[scan_idx_q];
	assign scan_last    = scan_idx_q == IDX_W'(TABLE_ENTRIES - 1);

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (request.valid) begin
					if ((request.operation == OP_DISPATCH) && (req_short || req_badlen)) begin
						state_next = SQ_DONE;
					end else begin
						state_next = SQ_SCAN;
					end
				end
			end
			SQ_SCAN: begin
				if (scan_hit || scan_last) begin
					state_next = SQ_DONE;
				end
			end
			SQ_DONE: begin
				if (result.ready) begin
					state_next = SQ_IDLE;
				end
			end
			default: state_next = SQ_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		request.ready = 1'b0;
		result.valid  = 1'b0;
		scan_active   = 1'b0;
		case (state_q)
			SQ_IDLE: request.ready = 1'b1;
			SQ_SCAN: scan_active   = 1'b1;
			SQ_DONE: result.valid  = 1'b1;
			default: ;
		endcase
	end

	// Handler, sender and payload fields are zero unless the datagram was delivered.
	assign res_delivered         = res_status_q == ST_DELIVERED;
	assign result.status         = res_status_q;
	assign result.target_handler = res_handler_q;
	assign result.sender_address = res_delivered ? item_saddr_q : 32'd0;
	assign result.sender_port    = res_delivered ? item_sport_q : 16'd0;
	assign result.payload_length = res_delivered ? item_plen_q : 16'd0;

	// Sequencer state and used marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			bind_used_q <= '0;
		end else begin
			state_q <= state_next;
			if (scan_active && !scan_hit && scan_last && (item_op_q == OP_REGISTER)) begin
				if (free_found_q) begin
					bind_used_q[free_idx_q] <= 1'b1;
				end else if (scan_free) begin
					bind_used_q[scan_idx_q] <= 1'b1;
				end
			end
		end
	end

	// Item capture, scan datapath, table writes and result registers.
	always_ff @(posedge clk) begin
		if (req_accept) begin
			item_op_q      <= op_t'(request.operation);
			item_port_q    <= request.port;
			item_handler_q <= request.handler_id;
			item_saddr_q   <= request.source_address;
			item_sport_q   <= request.header_source_port;
			item_plen_q    <= req_min_len - UDP_HDR_BYTES;
			scan_idx_q     <= '0;
			free_found_q   <= 1'b0;
			free_idx_q     <= '0;
			res_handler_q  <= 8'd0;
			if (request.operation == OP_DISPATCH) begin
				res_status_q <= req_short ? ST_SHORT : ST_BADLEN;
			end else begin
				res_status_q <= ST_BOUND;
			end
		end
		if (scan_active) begin
			if (scan_hit) begin
				// Existing binding: rebind it, or deliver to its handler.
				if (item_op_q == OP_REGISTER) begin
					bind_handler_q[scan_idx_q] <= item_handler_q;
					res_status_q               <= ST_BOUND;
				end else begin
					res_status_q  <= ST_DELIVERED;
					res_handler_q <= bind_handler_q[scan_idx_q];
				end
			end else if (scan_last) begin
				// End of table: claim the lowest free entry or report the miss.
				if (item_op_q == OP_REGISTER) begin
					if (free_found_q) begin
						bind_port_q[free_idx_q]    <= item_port_q;
						bind_handler_q[free_idx_q] <= item_handler_q;
						res_status_q               <= ST_BOUND;
					end else if (scan_free) begin
						bind_port_q[scan_idx_q]    <= item_port_q;
						bind_handler_q[scan_idx_q] <= item_handler_q;
						res_status_q               <= ST_BOUND;
					end else begin
						res_status_q <= ST_FULL;
					end
				end else begin
					res_status_q <= ST_NOHANDLER;
				end
			end else begin
				// Advance and remember the first free entry seen.
				scan_idx_q <= scan_idx_q + IDX_W'(1);
				if (scan_free && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= scan_idx_q;
				end
			end
		end
	end

	// No request is taken while a result is offered.
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(request.ready && result.valid))
		else $error("request accepted while result pending");

	// A delivered result always names a nonzero handler.
	a_deliver_handler: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.status == ST_DELIVERED)) |-> (result.target_handler != 8'd0))
		else $error("delivery to handler zero");

	// Binding items only report bound or full.
	a_register_status: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (item_op_q == OP_REGISTER)) |->
		((result.status == ST_BOUND) || (result.status == ST_FULL)))
		else $error("binding item with dispatch status");

	// Scan index never leaves the table.
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_active |-> (int'(scan_idx_q) < TABLE_ENTRIES))
		else $error("scan index out of range");

	// A table-full result leaves the used marks unchanged and all set.
	a_full_table: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.status == ST_FULL)) |-> (&bind_used_q))
		else $error("table full reported with a free entry");

endmodule : udp_port_demultiplexer_core
`default_nettype wire

@@ verif/udp_demux_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// UDP port demultiplexer checker
// Watches the request and result channels, keeps its own copy of the port
// binding table, works out the result of every accepted request beat and
// compares each accepted result beat field by field, oldest first.
// ---------------------------------------------------------------------------
module udp_demux_checker
	import udp_demux_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	udp_demux_req_if request,
	udp_demux_res_if result,
	output int       fail_count,
	output int       outstanding
);

	typedef struct packed {
		op_t         op;
		logic [15:0] port;
		logic [7:0]  handler_id;
		logic [31:0] source_address;
		logic [15:0] source_port;
		logic [15:0] header_length;
		logic [15:0] frame_length;
	} req_beat_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  target_handler;
		logic [31:0] sender_address;
		logic [15:0] sender_port;
		logic [15:0] payload_length;
	} res_beat_t;

	// Shadow copy of the binding table; it starts empty.
	bit          bound_used    [TABLE_ENTRIES];
	logic [15:0] bound_port    [TABLE_ENTRIES];
	logic [7:0]  bound_handler [TABLE_ENTRIES];

	res_beat_t expected_results[$];
	int        mismatches   = 0;
	int        queued_count = 0;

	assign fail_count  = mismatches;
	assign outstanding = queued_count;

	initial begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			bound_used[i]    = 1'b0;
			bound_port[i]    = '0;
			bound_handler[i] = '0;
		end
	end

	// Applies one request to the shadow table and returns the result it causes.
	function automatic res_beat_t route_request(input req_beat_t rq);
		res_beat_t   rs;
		logic [15:0] plen;
		bit          found;
		rs.status         = ST_BOUND;
		rs.target_handler = '0;
		rs.sender_address = '0;
		rs.sender_port    = '0;
		rs.payload_length = '0;
		found             = 1'b0;
		if (rq.op == OP_REGISTER) begin
			// Rebind an entry that already holds the port, else claim the lowest free one.
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (!found && bound_used[i] && bound_port[i] == rq.port) begin
					bound_handler[i] = rq.handler_id;
					found = 1'b1;
				end
			end
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (!found && !bound_used[i]) begin
					bound_used[i]    = 1'b1;
					bound_port[i]    = rq.port;
					bound_handler[i] = rq.handler_id;
					found = 1'b1;
				end
			end
			rs.status = found ? ST_BOUND : ST_FULL;
		end else if (rq.frame_length < UDP_HDR_BYTES) begin
			rs.status = ST_SHORT;
		end else if (rq.header_length < UDP_HDR_BYTES) begin
			rs.status = ST_BADLEN;
		end else begin
			// Payload length is clamped to what actually arrived.
			plen = rq.header_length - UDP_HDR_BYTES;
			if (plen > rq.frame_length - UDP_HDR_BYTES) begin
				plen = rq.frame_length - UDP_HDR_BYTES;
			end
			rs.status = ST_NOHANDLER;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (!found && bound_used[i] && bound_port[i] == rq.port &&
				    bound_handler[i] != 8'd0) begin
					rs.status         = ST_DELIVERED;
					rs.target_handler = bound_handler[i];
					rs.sender_address = rq.source_address;
					rs.sender_port    = rq.source_port;
					rs.payload_length = plen;
					found = 1'b1;
				end
			end
		end
		return rs;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Result beats are retired before a request beat of the same edge is predicted,
	// since a result always belongs to an earlier request.
	always @(posedge clk) begin
		req_beat_t rq;
		res_beat_t want;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no expected result: status %0d", result.status);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", 32'(want.status), 32'(result.status));
					check_field("target_handler", 32'(want.target_handler),
					            32'(result.target_handler));
					check_field("sender_address", want.sender_address, result.sender_address);
					check_field("sender_port", 32'(want.sender_port), 32'(result.sender_port));
					check_field("payload_length", 32'(want.payload_length),
					            32'(result.payload_length));
				end
			end
			if (request.valid && request.ready) begin
				rq.op             = op_t'(request.operation);
				rq.port           = request.port;
				rq.handler_id     = request.handler_id;
				rq.source_address = request.source_address;
				rq.source_port    = request.header_source_port;
				rq.header_length  = request.header_length;
				rq.frame_length   = request.frame_length;
				expected_results.push_back(route_request(rq));
			end
			queued_count = expected_results.size();
		end
	end

endmodule : udp_demux_checker
`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// UDP port demultiplexer testbench
// Drives binding and dispatch beats into the demultiplexer core, first a
// directed set for the corner cases and then random traffic over a small
// pool of ports, under several idle and stall patterns and one long result
// hold-off. A checker beside the core predicts and compares every result.
// ---------------------------------------------------------------------------
module tb;
	import udp_demux_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 100;
	localparam int POOL_SIZE     = 12;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   cycle_count   = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	bit   hold_request  = 1'b0;
	bit   hold_active   = 1'b0;

	logic [15:0] port_pool [POOL_SIZE];

	udp_demux_req_if request_ch ();
	udp_demux_res_if result_ch ();

	udp_port_demultiplexer_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request_ch),
		.result  (result_ch)
	);

	udp_demux_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.request     (request_ch),
		.result      (result_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Watchdog on the total run length.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Long hold-off of the result channel, counted here once requested.
	initial begin
		wait (hold_request);
		@(negedge clk);
		hold_active = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_active = 1'b0;
	end

	// Result side: random stalls at the falling edge.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready = !hold_active && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offers one request beat and returns at the falling edge after it is taken.
	task automatic offer_beat(input op_t op, input logic [15:0] port,
	                          input logic [7:0] handler, input logic [31:0] saddr,
	                          input logic [15:0] sport, input logic [15:0] hlen,
	                          input logic [15:0] flen);
		while ($urandom_range(99) < send_idle_pct) begin
			request_ch.valid = 1'b0;
			@(negedge clk);
		end
		request_ch.operation          = op;
		request_ch.port               = port;
		request_ch.handler_id         = handler;
		request_ch.source_address     = saddr;
		request_ch.header_source_port = sport;
		request_ch.header_length      = hlen;
		request_ch.frame_length       = flen;
		request_ch.valid              = 1'b1;
		do @(posedge clk); while (!request_ch.ready);
		@(negedge clk);
	endtask

	initial begin
		op_t         op;
		logic [15:0] port;
		logic [7:0]  handler;
		logic [15:0] hlen;
		logic [15:0] flen;
		int          pick;

		request_ch.valid              = 1'b0;
		request_ch.operation          = OP_REGISTER;
		request_ch.port               = '0;
		request_ch.handler_id         = '0;
		request_ch.source_address     = '0;
		request_ch.header_source_port = '0;
		request_ch.header_length      = '0;
		request_ch.frame_length       = '0;
		arst_n = 1'b0;

		// Distinct ports in the pool; the two extremes come first.
		port_pool[0] = 16'h0000;
		port_pool[1] = 16'hFFFF;
		for (int i = 2; i < POOL_SIZE; i++) begin
			port_pool[i] = 16'(i * 16'h1000) + 16'($urandom_range(4095));
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed corner cases, starting from the empty table.
		offer_beat(OP_DISPATCH, 16'h0000, 8'h00, 32'h0A000001, 16'd53, 16'd20, 16'd20);
		offer_beat(OP_DISPATCH, 16'h0000, 8'h00, 32'h0A000001, 16'd53, 16'd0, 16'd0);
		offer_beat(OP_DISPATCH, 16'h0000, 8'h00, 32'h0A000001, 16'd53, 16'hFFFF, 16'd7);
		offer_beat(OP_DISPATCH, 16'h0000, 8'h00, 32'h0A000001, 16'd53, 16'd7, 16'd8);
		offer_beat(OP_DISPATCH, 16'h0000, 8'h00, 32'h0A000001, 16'd53, 16'd0, 16'hFFFF);
		offer_beat(OP_REGISTER, 16'h0000, 8'hFF, 32'hDEADBEEF, 16'h1234, 16'd99, 16'd99);
		offer_beat(OP_DISPATCH, 16'h0000, 8'h00, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// Handler zero keeps the entry but never receives a datagram.
		offer_beat(OP_REGISTER, 16'hFFFF, 8'h00, 32'h0, 16'h0, 16'h0, 16'h0);
		offer_beat(OP_DISPATCH, 16'hFFFF, 8'h00, 32'h01020304, 16'd7, 16'd64, 16'd64);
		offer_beat(OP_REGISTER, 16'hFFFF, 8'h01, 32'h0, 16'h0, 16'h0, 16'h0);
		offer_beat(OP_DISPATCH, 16'hFFFF, 8'h00, 32'h01020304, 16'd7, 16'd100, 16'd20);
		offer_beat(OP_DISPATCH, 16'h0000, 8'h00, 32'h00000000, 16'h0000, 16'd8, 16'd8);
		offer_beat(OP_DISPATCH, 16'h0000, 8'h5A, 32'hC0A80001, 16'd4000, 16'd30, 16'd1000);
		// Fill the table, overflow it, then rebind an entry while it is full.
		for (int i = 2; i < 8; i++) begin
			offer_beat(OP_REGISTER, port_pool[i], 8'(i * 16), 32'h0, 16'h0, 16'h0, 16'h0);
		end
		offer_beat(OP_REGISTER, port_pool[8], 8'h77, 32'h0, 16'h0, 16'h0, 16'h0);
		offer_beat(OP_REGISTER, port_pool[3], 8'h00, 32'h0, 16'h0, 16'h0, 16'h0);
		offer_beat(OP_DISPATCH, port_pool[3], 8'h00, 32'h11111111, 16'd9, 16'd40, 16'd40);
		offer_beat(OP_DISPATCH, port_pool[8], 8'h00, 32'h22222222, 16'd9, 16'd40, 16'd40);

		// Random traffic under each idle pattern; the first one has the long hold-off.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					hold_request   = 1'b1;
				end
				1: begin
					send_idle_pct  = 52;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 52;
				end
				default: begin
					send_idle_pct  = 24;
					recv_stall_pct = 24;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				op   = ($urandom_range(99) < 25) ? OP_REGISTER : OP_DISPATCH;
				port = ($urandom_range(99) < 75) ? port_pool[$urandom_range(POOL_SIZE - 1)]
				                                 : 16'($urandom);
				handler = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255));
				// Mostly well-formed headers, some short frames and bad lengths.
				pick = $urandom_range(99);
				if (pick < 8) begin
					flen = 16'($urandom_range(7));
					hlen = 16'($urandom);
				end else if (pick < 16) begin
					flen = 16'($urandom_range(65535, 8));
					hlen = 16'($urandom_range(7));
				end else if (pick < 60) begin
					flen = 16'($urandom_range(200, 8));
					hlen = 16'($urandom_range(200, 8));
				end else begin
					flen = 16'($urandom_range(65535, 8));
					hlen = 16'($urandom_range(65535, 8));
				end
				offer_beat(op, port, handler, 32'($urandom), 16'($urandom), hlen, flen);
			end
		end
		request_ch.valid = 1'b0;

		// Drain, then allow the core's latency before the verdict.
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule : tb
`default_nettype wire

@@ files.f @@
hdl/udp_demux_pkg.sv
hdl/udp_demux_if.sv
hdl/udp_port_demultiplexer_core.sv
verif/udp_demux_checker.sv
verif/tb.sv
